/* design/bni_pkg.sv */
// Package for the batch normalization block: item types, register indexes,
// fixed-point constants. No dependencies.
package bni_pkg;
	localparam int MaxChannelsDef = 64;
	localparam int DataWidthDef = 32;
	localparam logic [31:0] QOne = 32'h0001_0000;
	localparam int CfgW = 17;

	typedef enum logic [2:0] {
		REG_NUM_CHANNELS = 3'd0,
		REG_PLANE_SIZE   = 3'd1,
		REG_BATCH_COUNT  = 3'd2,
		REG_EPS          = 3'd3,
		REG_AFFINE_ON    = 3'd4
	} reg_idx_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  channel;
		logic signed [31:0] mean_value;
		logic [30:0] variance;
		logic signed [31:0] weight_value;
		logic signed [31:0] bias_value;
		logic signed [31:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic [5:0]  out_channel;
		logic        end_of_tensor;
		logic        saturated;
	} out_item_t;
endpackage

/* design/bni_rsqrt.sv */
// Iterative inverse square root unit: floor(sqrt(floor(2^48 / s))).
// Restoring divide, then restoring square root, one bit per cycle. Uses bni_pkg.
module bni_rsqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] s,
	output logic        done,
	output logic [31:0] root
);
	import bni_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SQRT = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t         state_q;
	logic [5:0]  cnt_q;
	logic [49:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] div_q;
	logic [49:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic [32:0] rem_sh;
	logic [49:0] sq_sh;
	logic [49:0] sq_trial;

	assign rem_sh = {rem_q[31:0], quo_q[48]};
	assign sq_sh = {sq_rem_q[47:0], quo_q[49:48]};
	assign sq_trial = {16'd0, sq_root_q, 2'b01};
	assign done = (state_q == ST_DONE);
	assign root = sq_root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						cnt_q <= 6'd49;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= ST_SQRT;
						cnt_q <= 6'd25;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				quo_q <= {2'b01, 48'd0};
				rem_q <= '0;
				div_q <= s;
				sq_rem_q <= '0;
				sq_root_q <= '0;
			end
			ST_DIV: begin
				if (rem_sh >= {1'b0, div_q}) begin
					rem_q <= rem_sh - {1'b0, div_q};
					quo_q <= {1'b0, quo_q[47:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {1'b0, quo_q[47:0], 1'b0};
				end
			end
			ST_SQRT: begin
				quo_q <= {quo_q[47:0], 2'b00};
				if (sq_sh >= sq_trial) begin
					sq_rem_q <= sq_sh - sq_trial;
					sq_root_q <= {sq_root_q[30:0], 1'b1};
				end else begin
					sq_rem_q <= sq_sh;
					sq_root_q <= {sq_root_q[30:0], 1'b0};
				end
			end
			default: ;
		endcase
	end
endmodule

/* design/bni_core.sv */
// Parameter memory, stream position counters and the normalize datapath.
// Uses bni_pkg and bni_rsqrt.
module bni_core #(
	parameter int MAX_CHANNELS = bni_pkg::MaxChannelsDef,
	parameter int DATA_WIDTH = bni_pkg::DataWidthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  bni_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bni_pkg::out_item_t  out_item
);
	import bni_pkg::*;

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NchMax = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RSQ  = 5'b00010,
		S_MUL1 = 5'b00100,
		S_MUL2 = 5'b01000,
		S_OUT  = 5'b10000
	} st_t;

	typedef struct packed {
		logic signed [31:0] mean;
		logic [31:0] inv_std;
		logic signed [31:0] weight;
		logic signed [31:0] bias;
	} entry_t;

	entry_t mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] vld_q;
	logic [MAX_CHANNELS-1:0] wvld_q;
	entry_t rd_s1;
	logic rd_vld_s1, rd_wvld_s1;

	st_t state_q;
	logic [6:0]  nch_q;
	logic [16:0] ps_q;
	logic [10:0] bc_q;
	logic [16:0] eps_q;
	logic        aff_q;
	logic [15:0] ppos_q;
	logic [5:0]  cpos_q;
	logic [9:0]  ipos_q;

	in_item_t    it_q;
	logic [AW-1:0] ch_q;
	logic        rsq_start;
	logic        rsq_done;
	logic [31:0] rsq_root;
	logic [31:0] s_sum;

	logic [32:0] mag_q;
	logic        neg_q;
	logic [47:0] nm_q;
	logic        nneg_q;
	logic        eot_q;
	out_item_t   out_q;
	logic        mul_step_q;

	logic [6:0]  nch_e;
	logic [16:0] ps_e;
	logic [10:0] bc_e;
	logic        last_p, last_c, last_i;
	logic [AW-1:0] cur_ch;

	entry_t      ent;
	logic signed [32:0] diff;
	logic [64:0] prod1;
	logic [47:0] nm_c;

	logic signed [31:0] w_sel, b_sel;
	logic        negw;
	logic [31:0] wm;
	logic        sgn;
	logic [55:0] ph;
	logic [55:0] pl;
	logic [63:0] q2;
	logic [63:0] q2c;
	logic signed [64:0] val;
	logic signed [64:0] hi_v, lo_v;
	logic signed [31:0] res_c;
	logic        sat_c;

	assign nch_e = (nch_q == 7'd0) ? 7'd1 : ((nch_q > 7'(NchMax)) ? 7'(NchMax) : nch_q);
	assign ps_e = (ps_q == 17'd0) ? 17'd1 : ((ps_q > 17'd65536) ? 17'd65536 : ps_q);
	assign bc_e = (bc_q == 11'd0) ? 11'd1 : ((bc_q > 11'd1024) ? 11'd1024 : bc_q);
	assign last_p = ({1'b0, ppos_q} + 17'd1) >= ps_e;
	assign last_c = ({1'b0, cpos_q} + 7'd1) >= nch_e;
	assign last_i = ({1'b0, ipos_q} + 11'd1) >= bc_e;
	assign cur_ch = (32'(cpos_q) >= MAX_CHANNELS) ? '0 : AW'(cpos_q);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT) && !mul_step_q;
	assign out_item = out_q;

	assign s_sum = {1'b0, it_q.variance} + {15'd0, eps_q};
	assign rsq_start = (state_q == S_RSQ) && (s_sum != 32'd0) && !rsq_done;

	bni_rsqrt u_rsqrt (
		.clk(clk), .arst_n(arst_n), .start(rsq_start), .s(s_sum),
		.done(rsq_done), .root(rsq_root)
	);

	always_comb begin
		ent = rd_s1;
		if (!rd_vld_s1) begin
			ent.mean = '0;
			ent.inv_std = QOne;
		end
		if (!rd_wvld_s1) begin
			ent.weight = QOne;
			ent.bias = '0;
		end
		diff = 33'(it_q.sample) - 33'(ent.mean);
	end

	assign prod1 = mag_q * ent.inv_std;
	assign nm_c = neg_q ? 48'((prod1 + 65'h0FFFF) >> 16) : 48'(prod1 >> 16);

	always_comb begin
		w_sel = aff_q ? ent.weight : $signed(QOne);
		b_sel = aff_q ? ent.bias : '0;
		negw = w_sel[31];
		wm = negw ? 32'(-w_sel) : w_sel;
		sgn = nneg_q != negw;
		ph = 56'(nm_q[47:24]) * 56'(wm);
		pl = 56'(nm_q[23:0]) * 56'(wm);
		q2 = {ph[55:0], 8'd0} + (sgn ? 64'((pl + 56'h0FFFF) >> 16) : 64'(pl >> 16));
		q2c = (q2 > (64'd1 << 50)) ? (64'd1 << 50) : q2;
		val = (sgn ? -$signed({1'b0, q2c}) : $signed({1'b0, q2c})) + 65'(b_sel);
		hi_v = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
		lo_v = -hi_v - 65'sd1;
		sat_c = 1'b0;
		res_c = 32'(val);
		if (val > hi_v) begin
			res_c = 32'(hi_v);
			sat_c = 1'b1;
		end else if (val < lo_v) begin
			res_c = 32'(lo_v);
			sat_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RSQ && (s_sum == 32'd0 || rsq_done)) begin
			mem[ch_q].mean <= it_q.mean_value;
			mem[ch_q].inv_std <= (s_sum == 32'd0) ? 32'h7FFF_FFFF : rsq_root;
			if (aff_q) begin
				mem[ch_q].weight <= it_q.weight_value;
				mem[ch_q].bias <= it_q.bias_value;
			end
		end
		rd_s1 <= mem[cur_ch];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			wvld_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_wvld_s1 <= 1'b0;
			nch_q <= 7'd64;
			ps_q <= 17'd1;
			bc_q <= 11'd1;
			eps_q <= 17'd1;
			aff_q <= 1'b0;
			ppos_q <= '0;
			cpos_q <= '0;
			ipos_q <= '0;
		end else begin
			rd_vld_s1 <= vld_q[cur_ch];
			rd_wvld_s1 <= wvld_q[cur_ch];
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NUM_CHANNELS: nch_q <= cfg_data[6:0];
					REG_PLANE_SIZE:   ps_q <= cfg_data;
					REG_BATCH_COUNT:  bc_q <= cfg_data[10:0];
					REG_EPS:          eps_q <= cfg_data;
					REG_AFFINE_ON:    aff_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_item.cmd == CMD_SAMPLE) state_q <= S_MUL1;
						else if (32'(in_item.channel) < MAX_CHANNELS) state_q <= S_RSQ;
					end
				end
				S_RSQ: begin
					if (s_sum == 32'd0 || rsq_done) begin
						vld_q[ch_q] <= 1'b1;
						if (aff_q) wvld_q[ch_q] <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					state_q <= S_OUT;
					if (last_p) begin
						ppos_q <= '0;
						if (last_c) begin
							cpos_q <= '0;
							ipos_q <= last_i ? '0 : ipos_q + 10'd1;
						end else begin
							cpos_q <= cpos_q + 6'd1;
						end
					end else begin
						ppos_q <= ppos_q + 16'd1;
					end
				end
				S_OUT: if (out_ready && !mul_step_q) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			it_q <= in_item;
			ch_q <= AW'(in_item.channel);
		end
		if (state_q == S_MUL1) begin
			neg_q <= diff < 0;
			mag_q <= diff[32] ? 33'(-diff) : 33'(diff);
			ch_q <= cur_ch;
		end
		if (state_q == S_MUL2) begin
			eot_q <= last_p && last_c && last_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_step_q <= 1'b0;
		else mul_step_q <= (state_q == S_MUL2);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL2) begin
			nm_q <= nm_c;
			nneg_q <= neg_q && (nm_c != 48'd0);
		end
		if (mul_step_q) begin
			out_q.result <= res_c;
			out_q.out_channel <= 6'(ch_q);
			out_q.end_of_tensor <= eot_q;
			out_q.saturated <= sat_c;
		end
	end
endmodule

/* design/batch_norm_inference.sv */
// Channel   | Direction | Handshake
// in_item   | input     | in_valid / in_ready
// out_item  | output    | out_valid / out_ready
// cfg       | input     | cfg_we, write only
// A sample item passes S_MUL1, S_MUL2 and the result register before it is shown.
// The next item is taken only after a sample item's result has left S_OUT.
// A load item holds the input while the iterative inverse-root unit runs,
// or only through S_RSQ when variance plus eps is zero.
// Reset: arst_n clears counters and marks all parameter entries as defaults.
// A stalled result holds the block; no new item is taken until it leaves.
module batch_norm_inference #(
	parameter int MAX_CHANNELS = bni_pkg::MaxChannelsDef,
	parameter int DATA_WIDTH = bni_pkg::DataWidthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  bni_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output bni_pkg::out_item_t out_item
);
	import bni_pkg::*;

	bni_core #(.MAX_CHANNELS(MAX_CHANNELS), .DATA_WIDTH(DATA_WIDTH)) u_core (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);
endmodule

/* design/bni_checker.sv */
// Port-level checker for batch_norm_inference, bound to the top level.
// Uses bni_pkg.
module bni_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input bni_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input bni_pkg::out_item_t out_item
);
	import bni_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	a_sample_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.cmd == CMD_SAMPLE |=> ##3 out_valid)
		else $error("sample result missing");
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.cmd == CMD_LOAD |=> !out_valid)
		else $error("load produced a result");
endmodule

bind batch_norm_inference bni_checker u_bni_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
	.out_item(out_item)
);
